// ----- hw/rtl/unicode_caseless_compare_macros.svh -----
// Assertion macros for the caseless compare block.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef UNICODE_CASELESS_COMPARE_MACROS_SVH
`define UNICODE_CASELESS_COMPARE_MACROS_SVH

// same-cycle implication
`define UCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ucc assertion failed");

// next-cycle implication
`define UCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucc assertion failed");

`endif

// ----- hw/rtl/ucc_pkg.sv -----
// Shared types and constants for the caseless UTF-16 compare block.
// No dependencies.
package ucc_pkg;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;
   localparam int CODE_W      = 16;
   localparam int LEN_W       = 16;

   typedef logic [1:0]              order_type;
   typedef logic signed [CODE_W-1:0] code_type;
   typedef logic [LEN_W-1:0]        len_type;

   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_PAIR  = 1'b1;

   localparam order_type ORDER_LESS    = 2'b11;
   localparam order_type ORDER_EQUAL   = 2'b00;
   localparam order_type ORDER_GREATER = 2'b01;
   localparam order_type ORDER_UNUSED  = 2'b10;

endpackage

// ----- hw/rtl/ucc_fold.sv -----
// Lower-case folding of one UTF-16 code (Latin, Latin Extended, Cyrillic).
// Depends on ucc_pkg.
module ucc_fold (
   input  ucc_pkg::code_type code_in,
   output ucc_pkg::code_type code_out
);

   logic [15:0] u;
   logic        even;

   assign u    = code_in;
   assign even = ~u[0];

   always_comb begin
      priority if (u >= 16'h0041 && u <= 16'h005a) begin
         code_out = code_in + 16'sh0020;
      end else if (u >= 16'h0410 && u <= 16'h042f) begin
         code_out = code_in + 16'sh0020;
      end else if (u >= 16'h0400 && u <= 16'h040f) begin
         code_out = code_in + 16'sh0050;
      end else if (u >= 16'h00c0 && u <= 16'h00de && u != 16'h00d7) begin
         code_out = code_in + 16'sh0020;
      end else if ((even && ((u >= 16'h0100 && u <= 16'h0136) ||
                             (u >= 16'h014a && u <= 16'h0176) ||
                             (u >= 16'h01e4 && u <= 16'h01ea) ||
                             (u >= 16'h01fa && u <= 16'h01fe) ||
                             (u >= 16'h0490 && u <= 16'h04e8))) ||
                   (!even && ((u >= 16'h0139 && u <= 16'h0147) ||
                              (u >= 16'h0179 && u <= 16'h017d))) ||
                   u == 16'h01a0 || u == 16'h01af || u == 16'h01ee ||
                   u == 16'h0218 || u == 16'h021a || u == 16'h0228) begin
         code_out = code_in + 16'sh0001;
      end else if (u == 16'h0178) begin
         code_out = 16'sh00ff;
      end else if (u == 16'h018f) begin
         code_out = 16'sh0259;
      end else if (u == 16'h01b7) begin
         code_out = 16'sh0292;
      end else begin
         code_out = code_in;
      end
   end

endmodule

// ----- hw/rtl/unicode_caseless_compare.sv -----
// Caseless UTF-16 string compare, one character pair per transfer.
// Result path: input register, single fold/compare stage, result register.
// Throughput: one input transfer per cycle unless a held result stalls it.
// Reset: synchronous, active high; clears state and both stage valids.
// Depends on ucc_pkg, ucc_fold and unicode_caseless_compare_macros.svh.
`include "unicode_caseless_compare_macros.svh"

module unicode_caseless_compare (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // len_a[15:0], len_b[31:16], char_a[47:32], char_b[63:48]
   input  logic [ucc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // order[1:0], zero fill above
   output logic [ucc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_action_ff;
   ucc_pkg::len_type   s1_len_a_ff, s1_len_b_ff;
   ucc_pkg::code_type  s1_char_a_ff, s1_char_b_ff;

   // comparison state
   ucc_pkg::len_type   pairs_left_ff, pairs_left_in;
   logic               comparing_ff, comparing_in;
   ucc_pkg::order_type verdict_ff, verdict_in;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   ucc_pkg::order_type rsp_order_ff;

   logic               req_fire, s1_go, s1_fire, s1_emit;
   ucc_pkg::order_type emit_order, pair_order, merged;
   ucc_pkg::code_type  fold_a, fold_b;
   ucc_pkg::len_type   pairs_dec;

   ucc_fold u_fold_a (.code_in(s1_char_a_ff), .code_out(fold_a));
   ucc_fold u_fold_b (.code_in(s1_char_b_ff), .code_out(fold_b));

   assign s1_go      = ~rsp_valid_ff | rsp_tready;
   assign s1_fire    = s1_valid_ff & s1_go;
   assign req_tready = ~s1_valid_ff | s1_go;
   assign req_fire   = req_tvalid & req_tready;
   assign pairs_dec  = pairs_left_ff - 16'd1;

   always_comb begin
      priority if (fold_a < fold_b) begin
         pair_order = ucc_pkg::ORDER_LESS;
      end else if (fold_a > fold_b) begin
         pair_order = ucc_pkg::ORDER_GREATER;
      end else begin
         pair_order = ucc_pkg::ORDER_EQUAL;
      end
   end

   assign merged = (verdict_ff == ucc_pkg::ORDER_EQUAL) ? pair_order : verdict_ff;

   always_comb begin
      pairs_left_in = pairs_left_ff;
      comparing_in  = comparing_ff;
      verdict_in    = verdict_ff;
      s1_emit       = 1'b0;
      emit_order    = ucc_pkg::ORDER_EQUAL;
      if (s1_fire) begin
         if (s1_action_ff == ucc_pkg::ACTION_BEGIN) begin
            comparing_in  = 1'b0;
            pairs_left_in = '0;
            verdict_in    = ucc_pkg::ORDER_EQUAL;
            priority if (s1_len_a_ff < s1_len_b_ff) begin
               s1_emit    = 1'b1;
               emit_order = ucc_pkg::ORDER_LESS;
            end else if (s1_len_a_ff > s1_len_b_ff) begin
               s1_emit    = 1'b1;
               emit_order = ucc_pkg::ORDER_GREATER;
            end else if (s1_len_a_ff == '0) begin
               s1_emit    = 1'b1;
               emit_order = ucc_pkg::ORDER_EQUAL;
            end else begin
               pairs_left_in = s1_len_a_ff;
               comparing_in  = 1'b1;
            end
         end else if (comparing_ff) begin
            pairs_left_in = pairs_dec;
            if (pairs_dec == '0) begin
               comparing_in = 1'b0;
               verdict_in   = ucc_pkg::ORDER_EQUAL;
               s1_emit      = 1'b1;
               emit_order   = merged;
            end else begin
               verdict_in = merged;
            end
         end
      end
   end

   assign s1_valid_in  = req_fire | (s1_valid_ff & ~s1_go);
   assign rsp_valid_in = s1_emit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pairs_left_ff <= '0;
         comparing_ff  <= 1'b0;
         verdict_ff    <= ucc_pkg::ORDER_EQUAL;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pairs_left_ff <= pairs_left_in;
         comparing_ff  <= comparing_in;
         verdict_ff    <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_tuser;
         s1_len_a_ff  <= req_tdata[15:0];
         s1_len_b_ff  <= req_tdata[31:16];
         s1_char_a_ff <= req_tdata[47:32];
         s1_char_b_ff <= req_tdata[63:48];
      end
      if (s1_emit) begin
         rsp_order_ff <= emit_order;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ucc_pkg::RSP_TDATA_W-2){1'b0}}, rsp_order_ff};

   `UCC_ASSERT_IMP(a_pairs_nonzero, clock, reset, comparing_ff, pairs_left_ff != '0)
   `UCC_ASSERT_IMP(a_idle_verdict, clock, reset, !comparing_ff, verdict_ff == ucc_pkg::ORDER_EQUAL)
   `UCC_ASSERT_IMP(a_order_code, clock, reset, rsp_valid_ff, rsp_order_ff != ucc_pkg::ORDER_UNUSED)
   `UCC_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !s1_emit)
   `UCC_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_char_a_ff))

endmodule
